// ===== sv/symmetric_grid_hash_distinct_counter_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the symmetric grid hash counter
// Shared concurrent assertion forms, clocked on the rising edge with reset
// as the disable condition.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_GRID_HASH_DISTINCT_COUNTER_TOP_ASSERT_SVH
`define SYMMETRIC_GRID_HASH_DISTINCT_COUNTER_TOP_ASSERT_SVH

// condition holds on every clock edge out of reset
`define SGHDC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SGHDC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define SGHDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sghdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sghdc_pkg
// Constants, shared types and helper functions of the symmetric grid hash
// distinct counter.
// ----------------------------------------------------------------------------
package sghdc_pkg;

   // hash arithmetic
   localparam int unsigned HASH_MOD = 1000001;
   localparam int unsigned BASE_ROW = 907;
   localparam int unsigned BASE_COL = 1009;
   localparam int HASH_W  = 20;
   localparam int COUNT_W = 20;

   // side register
   localparam int CSR_W      = 6;
   localparam int SIDE_RESET = 32;

   // default sizes
   localparam int MAX_SIDE_DEF    = 32;
   localparam int IN_Q_DEPTH_DEF  = 4;
   localparam int OUT_Q_DEPTH_DEF = 8;

   // seen bitmap organised as 64-bit rows
   localparam int SEEN_WORD_W = 64;
   localparam int SEEN_BIT_W  = 6;
   localparam int SEEN_ROW_W  = HASH_W - SEEN_BIT_W;
   localparam int SEEN_ROWS   = (HASH_MOD + SEEN_WORD_W - 1) / SEEN_WORD_W;

   // finished grid hash handed to the bitmap stage
   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
   } fin_type;

   // one result
   typedef struct packed {
      logic [HASH_W-1:0]  grid_hash;
      logic               is_new;
      logic [COUNT_W-1:0] distinct_count;
   } rsp_type;

   // sum of two residues, both below the modulus
   function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b);
      logic [HASH_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (HASH_W+1)'(HASH_MOD)) begin
         sum = sum - (HASH_W+1)'(HASH_MOD);
      end
      return sum[HASH_W-1:0];
   endfunction

   // P^x * Q^y mod M, for building the power table at elaboration
   function automatic logic [HASH_W-1:0] pow_entry(input int unsigned x,
                                                    input int unsigned y);
      logic [63:0] acc;
      acc = 64'd1;
      for (int unsigned k = 0; k < x; k++) begin
         acc = (acc * BASE_ROW) % HASH_MOD;
      end
      for (int unsigned k = 0; k < y; k++) begin
         acc = (acc * BASE_COL) % HASH_MOD;
      end
      return acc[HASH_W-1:0];
   endfunction

endpackage

// ===== sv/sghdc_fifo.sv =====
// ----------------------------------------------------------------------------
// sghdc_fifo
// Small register queue with push, pop, fill count and full/empty flags.
// ----------------------------------------------------------------------------
module sghdc_fifo
   import sghdc_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = IN_Q_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = slot_ff[rd_ptr_ff];
   assign not_empty = (fill_ff != '0);
   assign full      = (fill_ff == CNT_W'(DEPTH));

endmodule

// ===== sv/sghdc_front.sv =====
// ----------------------------------------------------------------------------
// sghdc_front
// Accepts cell requests, tracks row and column, and queues the cells that
// need work in the back end: filled cells and the last cell of each grid.
// ----------------------------------------------------------------------------
module sghdc_front
   import sghdc_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEF,
   localparam int IDX_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
   localparam int OP_W    = 4 * IDX_W + 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   input  logic             req_valid,
   input  logic             req_cell_req,
   output logic             req_ready,
   input  logic             clr_busy,
   input  logic             q_full,
   output logic             q_push,
   output logic [OP_W-1:0]  q_op
);

   localparam int SIDE_RESET_EFF = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
   localparam logic [IDX_W-1:0] SIDE_MAX_RST = IDX_W'(SIDE_RESET_EFF - 1);

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] row_mirror;
      logic [IDX_W-1:0] col_mirror;
      logic             filled;
      logic             last;
   } cell_op_type;

   logic [IDX_W-1:0] side_max_ff, side_max_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic             accept;
   logic             last_col, last_row;
   cell_op_type      op;

   // effective side minus one: zero acts as one, oversize clamps
   always_comb begin
      if (csr_wr_data == '0) begin
         side_max_in = '0;
      end else if ({1'b0, csr_wr_data} > (CSR_W+1)'(MAX_SIDE)) begin
         side_max_in = IDX_W'(MAX_SIDE - 1);
      end else begin
         side_max_in = IDX_W'(csr_wr_data - CSR_W'(1));
      end
   end

   assign req_ready = !clr_busy && !q_full;
   assign accept    = req_valid && req_ready;
   assign last_col  = (col_ff == side_max_ff);
   assign last_row  = (row_ff == side_max_ff);

   // row-major scan position
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (csr_wr_en) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_max_ff <= SIDE_MAX_RST;
         row_ff      <= '0;
         col_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            side_max_ff <= side_max_in;
         end
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // classify: empty cells that do not close a grid need no work
   always_comb begin
      op.row        = row_ff;
      op.col        = col_ff;
      op.row_mirror = side_max_ff - row_ff;
      op.col_mirror = side_max_ff - col_ff;
      op.filled     = req_cell_req;
      op.last       = last_row && last_col;
   end

   assign q_push = accept && (op.filled || op.last);
   assign q_op   = op;

endmodule

// ===== sv/sghdc_back.sv =====
// ----------------------------------------------------------------------------
// sghdc_back
// Power table lookups and modular accumulation of the running grid hash.
// A filled cell issues four table reads per cycle, first with its column and then with its mirror.
// ----------------------------------------------------------------------------
`include "symmetric_grid_hash_distinct_counter_top_assert.svh"

module sghdc_back
   import sghdc_pkg::*;
#(
   parameter int MAX_SIDE  = MAX_SIDE_DEF,
   parameter int OUT_DEPTH = OUT_Q_DEPTH_DEF,
   localparam int IDX_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
   localparam int OP_W     = 4 * IDX_W + 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic            q_valid,
   input  logic [OP_W-1:0] q_op,
   output logic            q_pop,
   input  logic            rsp_taken,
   output fin_type         fin
);

   localparam int ROM_AW    = 2 * IDX_W;
   localparam int ROM_DEPTH = 1 << ROM_AW;
   localparam int CRED_W    = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] row_mirror;
      logic [IDX_W-1:0] col_mirror;
      logic             filled;
      logic             last;
   } cell_op_type;

   typedef logic [HASH_W-1:0] pow_rom_type [ROM_DEPTH];

   // table indexed by {x, y}, zero beyond the largest side
   function automatic pow_rom_type build_pow_rom();
      pow_rom_type rom;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         if ((k >> IDX_W) < MAX_SIDE && (k % (1 << IDX_W)) < MAX_SIDE) begin
            rom[k] = pow_entry(k >> IDX_W, k % (1 << IDX_W));
         end else begin
            rom[k] = '0;
         end
      end
      return rom;
   endfunction

   // two copies, each read at two addresses a cycle
   localparam pow_rom_type POW_BANK_A = build_pow_rom();
   localparam pow_rom_type POW_BANK_B = build_pow_rom();

   cell_op_type       head_op;
   cell_op_type       iss_op_ff;
   logic              iss_valid_ff, iss_phase_ff, iss_phase_in;
   logic              iss_done, iss_free;
   logic [CRED_W-1:0] credit_ff, credit_in;
   logic              credit_ok;
   logic [IDX_W-1:0]  col_sel;
   logic [ROM_AW-1:0] addr0, addr1, addr2, addr3;

   logic              rd_valid_ff, rd_add_ff, rd_last_ff;
   logic [HASH_W-1:0] pow0_ff, pow1_ff, pow2_ff, pow3_ff;
   logic              p1_valid_ff, p1_add_ff, p1_last_ff;
   logic [HASH_W-1:0] s01_ff, s23_ff;
   logic              p2_valid_ff, p2_add_ff, p2_last_ff;
   logic [HASH_W-1:0] sum_ff;
   logic [HASH_W-1:0] hash_ff, hash_next;
   logic              fin_valid_ff;
   logic [HASH_W-1:0] fin_hash_ff;

   assign head_op = cell_op_type'(q_op);

   // issue stage: filled cells hold it for two phases
   assign iss_done  = iss_valid_ff && (!iss_op_ff.filled || iss_phase_ff);
   assign iss_free  = !iss_valid_ff || iss_done;
   assign credit_ok = (credit_ff < CRED_W'(OUT_DEPTH));
   assign q_pop     = q_valid && iss_free && (!head_op.last || credit_ok);

   always_comb begin
      if (q_pop) begin
         iss_phase_in = 1'b0;
      end else if (iss_valid_ff && !iss_done) begin
         iss_phase_in = 1'b1;
      end else begin
         iss_phase_in = iss_phase_ff;
      end
      credit_in = credit_ff + CRED_W'(q_pop && head_op.last) - CRED_W'(rsp_taken);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_valid_ff <= 1'b0;
         iss_phase_ff <= 1'b0;
         credit_ff    <= '0;
      end else begin
         iss_valid_ff <= q_pop || (iss_valid_ff && !iss_done);
         iss_phase_ff <= iss_phase_in;
         credit_ff    <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         iss_op_ff <= head_op;
      end
   end

   // phase 0 takes the column, phase 1 its mirror
   assign col_sel = iss_phase_ff ? iss_op_ff.col_mirror : iss_op_ff.col;
   assign addr0   = {iss_op_ff.row, col_sel};
   assign addr1   = {col_sel, iss_op_ff.row};
   assign addr2   = {iss_op_ff.row_mirror, col_sel};
   assign addr3   = {col_sel, iss_op_ff.row_mirror};

   // control flags down the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= iss_valid_ff;
         p1_valid_ff  <= rd_valid_ff;
         p2_valid_ff  <= p1_valid_ff;
         fin_valid_ff <= p2_valid_ff && p2_last_ff;
      end
   end

   // table reads and the residue adder tree
   always_ff @(posedge clock) begin
      rd_add_ff  <= iss_op_ff.filled;
      rd_last_ff <= iss_op_ff.last && iss_done;
      pow0_ff    <= POW_BANK_A[addr0];
      pow1_ff    <= POW_BANK_A[addr1];
      pow2_ff    <= POW_BANK_B[addr2];
      pow3_ff    <= POW_BANK_B[addr3];
      p1_add_ff  <= rd_add_ff;
      p1_last_ff <= rd_last_ff;
      s01_ff     <= mod_add(pow0_ff, pow1_ff);
      s23_ff     <= mod_add(pow2_ff, pow3_ff);
      p2_add_ff  <= p1_add_ff;
      p2_last_ff <= p1_last_ff;
      sum_ff     <= mod_add(s01_ff, s23_ff);
   end

   // running hash, restarted at each grid end and on a side write
   assign hash_next = p2_add_ff ? mod_add(hash_ff, sum_ff) : hash_ff;

   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         hash_ff <= '0;
      end else if (p2_valid_ff) begin
         hash_ff <= p2_last_ff ? '0 : hash_next;
      end
   end

   always_ff @(posedge clock) begin
      fin_hash_ff <= hash_next;
   end

   assign fin.valid = fin_valid_ff;
   assign fin.hash  = fin_hash_ff;

   `SGHDC_ASSERT_ALWAYS(a_credit_bound, clock, reset, credit_ff <= CRED_W'(OUT_DEPTH), "result credit overrun")
   `SGHDC_ASSERT_NEXT(a_two_phase, clock, reset, iss_valid_ff && iss_op_ff.filled && !iss_phase_ff, iss_valid_ff && iss_phase_ff, "filled cell left issue early")
   `SGHDC_ASSERT_IMPLIES(a_fin_reduced, clock, reset, fin_valid_ff, fin_hash_ff < HASH_W'(HASH_MOD), "grid hash not reduced")

endmodule

// ===== sv/sghdc_seen.sv =====
// ----------------------------------------------------------------------------
// sghdc_seen
// Seen-hash bitmap with read-modify-write per finished grid, the distinct
// counter, and the clearing sweep after reset.
// ----------------------------------------------------------------------------
`include "symmetric_grid_hash_distinct_counter_top_assert.svh"

module sghdc_seen
   import sghdc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  fin_type fin,
   output logic    clr_busy,
   output logic    res_push,
   output rsp_type res_data
);

   localparam logic [SEEN_ROW_W-1:0] SEEN_ROW_LAST = SEEN_ROW_W'(SEEN_ROWS - 1);

   logic [SEEN_WORD_W-1:0] seen_mem [SEEN_ROWS];

   logic                   clr_busy_ff;
   logic [SEEN_ROW_W-1:0]  clr_row_ff;
   logic [SEEN_WORD_W-1:0] rd_word_ff;
   logic                   f1_valid_ff;
   logic [HASH_W-1:0]      f1_hash_ff;
   logic [SEEN_ROW_W-1:0]  f1_row;
   logic                   fwd_valid_ff;
   logic [SEEN_ROW_W-1:0]  fwd_row_ff;
   logic [SEEN_WORD_W-1:0] fwd_word_ff;
   logic [SEEN_WORD_W-1:0] word_cur, bit_mask, word_set;
   logic                   fresh;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   wr_en;
   logic [SEEN_ROW_W-1:0]  wr_row;
   logic [SEEN_WORD_W-1:0] wr_word;

   // clearing sweep, one row a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_busy_ff <= (clr_row_ff != SEEN_ROW_LAST);
         clr_row_ff  <= clr_row_ff + 1'b1;
      end
   end

   assign clr_busy = clr_busy_ff;

   // bitmap read for an arriving hash
   always_ff @(posedge clock) begin
      rd_word_ff <= seen_mem[fin.hash[HASH_W-1:SEEN_BIT_W]];
      f1_hash_ff <= fin.hash;
   end

   assign f1_row = f1_hash_ff[HASH_W-1:SEEN_BIT_W];

   // forward the previous write when it hit the same row
   always_comb begin
      word_cur = (fwd_valid_ff && fwd_row_ff == f1_row) ? fwd_word_ff : rd_word_ff;
      bit_mask = SEEN_WORD_W'(1) << f1_hash_ff[SEEN_BIT_W-1:0];
      fresh    = ((word_cur & bit_mask) == '0);
      word_set = word_cur | bit_mask;
      count_in = fresh ? count_ff + 1'b1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         f1_valid_ff  <= fin.valid;
         fwd_valid_ff <= f1_valid_ff && fresh;
         if (f1_valid_ff) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_row_ff  <= f1_row;
      fwd_word_ff <= word_set;
   end

   // single write port shared by the sweep and the marking
   assign wr_en   = clr_busy_ff || (f1_valid_ff && fresh);
   assign wr_row  = clr_busy_ff ? clr_row_ff : f1_row;
   assign wr_word = clr_busy_ff ? '0 : word_set;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seen_mem[wr_row] <= wr_word;
      end
   end

   // result
   assign res_push                = f1_valid_ff;
   assign res_data.grid_hash      = f1_hash_ff;
   assign res_data.is_new         = fresh;
   assign res_data.distinct_count = count_in;

   `SGHDC_ASSERT_IMPLIES(a_no_fin_in_clear, clock, reset, fin.valid, !clr_busy_ff, "grid finished during bitmap clear")
   `SGHDC_ASSERT_NEXT(a_count_hold, clock, reset, !f1_valid_ff, $stable(count_ff), "distinct count moved without a grid")
   `SGHDC_ASSERT_IMPLIES(a_clear_span, clock, reset, $fell(clr_busy_ff), $past(clr_row_ff) == SEEN_ROW_LAST, "bitmap clear ended early")

endmodule

// ===== sv/symmetric_grid_hash_distinct_counter_top.sv =====
// ----------------------------------------------------------------------------
// symmetric_grid_hash_distinct_counter_top
// Hashes square binary grids, one cell per request in row-major order, into
// a value modulo 1000001 that is the same for all eight rotations and
// reflections of a grid, and counts distinct hashes since reset. The front
// end takes one cell request a cycle unless the input queue is full or the
// bitmap is being cleared; empty cells that do not end a grid are not queued.
// Each filled cell needs eight power-table reads on two dual-port table
// copies, its column then its mirror, and holds the back end until both are
// issued. A grid's result passes the queue, issue, table read, adder tree,
// hash and bitmap read stages, arriving later while the back end is busy with
// earlier cells. It waits in an eight-entry result queue, so input keeps
// flowing while the result side stalls until that queue's entries are all
// claimed. After reset the 15626-row, 64-bit seen-hash bitmap is cleared
// one row a cycle, during which req_ready stays low. A side_length write
// takes effect at once and restarts the grid in progress; write it only
// while no request is still in flight.
// ----------------------------------------------------------------------------
module symmetric_grid_hash_distinct_counter_top
   import sghdc_pkg::*;
#(
   parameter int MAX_SIDE    = MAX_SIDE_DEF,
   parameter int IN_Q_DEPTH  = IN_Q_DEPTH_DEF,
   parameter int OUT_Q_DEPTH = OUT_Q_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CSR_W-1:0]   csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cell_req,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [HASH_W-1:0]  rsp_grid_hash,
   output logic               rsp_is_new,
   output logic [COUNT_W-1:0] rsp_distinct_count
);

   localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int OP_W  = 4 * IDX_W + 2;
   localparam int RSP_W = $bits(rsp_type);

   logic            clr_busy;
   logic            inq_push, inq_pop, inq_valid, inq_full;
   logic [OP_W-1:0] inq_wr_op, inq_rd_op;
   fin_type         fin;
   logic            res_push;
   rsp_type         res_data;
   logic            outq_full;
   logic            rsp_taken;
   logic [RSP_W-1:0] outq_head;
   rsp_type         rsp_head;

   // request intake and classification
   sghdc_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_cell_req (req_cell_req),
      .req_ready    (req_ready),
      .clr_busy     (clr_busy),
      .q_full       (inq_full),
      .q_push       (inq_push),
      .q_op         (inq_wr_op)
   );

   // queue between front and back
   sghdc_fifo #(
      .WIDTH (OP_W),
      .DEPTH (IN_Q_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (inq_push),
      .push_data (inq_wr_op),
      .pop       (inq_pop),
      .pop_data  (inq_rd_op),
      .not_empty (inq_valid),
      .full      (inq_full)
   );

   // table lookups and hash accumulation
   sghdc_back #(
      .MAX_SIDE  (MAX_SIDE),
      .OUT_DEPTH (OUT_Q_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .q_valid   (inq_valid),
      .q_op      (inq_rd_op),
      .q_pop     (inq_pop),
      .rsp_taken (rsp_taken),
      .fin       (fin)
   );

   // seen bitmap and distinct count
   sghdc_seen u_seen (
      .clock    (clock),
      .reset    (reset),
      .fin      (fin),
      .clr_busy (clr_busy),
      .res_push (res_push),
      .res_data (res_data)
   );

   // result queue, sized by the back end's credits
   sghdc_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_Q_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .pop       (rsp_taken),
      .pop_data  (outq_head),
      .not_empty (rsp_valid),
      .full      (outq_full)
   );

   assign rsp_taken          = rsp_valid && rsp_ready;
   assign rsp_head           = rsp_type'(outq_head);
   assign rsp_grid_hash      = rsp_head.grid_hash;
   assign rsp_is_new         = rsp_head.is_new && !outq_full | rsp_head.is_new;
   assign rsp_distinct_count = rsp_head.distinct_count;

endmodule
